// ===== rtl/htu_pkg.sv =====
// ----------------------------------------------------------------------------
// htu_pkg
// shared types and constants of the hold-to-unlock gesture qualifier
// ----------------------------------------------------------------------------
package htu_pkg;

  // hit-test slop around the button rectangle, in pixels
  localparam int HIT_SLOP = 8;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_PANEL_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PANEL_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRACE_TIME   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SAVER_ONLY   = 3'd5;

  // reset values of the registers
  localparam logic [10:0] RST_PANEL_WIDTH  = 11'd320;
  localparam logic [10:0] RST_PANEL_HEIGHT = 11'd240;
  localparam logic [15:0] RST_HOLD_TIME    = 16'd1000;
  localparam logic [15:0] RST_GRACE_TIME   = 16'd150;
  localparam logic [19:0] RST_IDLE_TIMEOUT = 20'd10000;

  // input item kind
  localparam logic ACT_ENTER = 1'b0;

  // percent quotient width and the top shift of the divider
  localparam int          PCT_W     = 7;
  localparam int          REM_W     = 23;
  localparam logic [2:0]  DIV_SHIFT = 3'(PCT_W - 1);

  typedef enum logic [1:0] {
    OUT_LOCKED   = 2'd0,
    OUT_UNLOCKED = 2'd1,
    OUT_SAVER    = 2'd2,
    OUT_SLEEP    = 2'd3
  } outcome_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_GRACE_D,
    S_GRACE_C,
    S_HOLD_D,
    S_HOLD_C,
    S_IDLE_D,
    S_IDLE_C,
    S_DIV,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    ALU_GRACE_D,
    ALU_GRACE_C,
    ALU_HOLD_D,
    ALU_HOLD_C,
    ALU_IDLE_D,
    ALU_IDLE_C,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic [31:0]      now;
    logic [31:0]      last_contact;
    logic [31:0]      hold_start;
    logic [31:0]      last_activity;
    logic [31:0]      diff;
    logic [15:0]      grace;
    logic [15:0]      hold_time;
    logic [19:0]      idle;
    logic [REM_W-1:0] rem;
    logic [2:0]       shift;
  } alu_opnd_t;

  typedef struct packed {
    logic [31:0] res;
    logic        borrow;
  } alu_res_t;

endpackage

// ===== rtl/htu_alu.sv =====
// ----------------------------------------------------------------------------
// htu_alu
// shared subtractor: time differences, limit compares and divide steps
// ----------------------------------------------------------------------------
module htu_alu (
  input  htu_pkg::alu_op_t  op,
  input  htu_pkg::alu_opnd_t opnd,
  output htu_pkg::alu_res_t  result
);

  logic [31:0] a;
  logic [31:0] b;
  logic [32:0] wide;

  always_comb begin
    a = '0;
    b = '0;
    unique case (op)
      htu_pkg::ALU_GRACE_D: begin
        a = opnd.now;
        b = opnd.last_contact;
      end
      // borrow: gap longer than grace
      htu_pkg::ALU_GRACE_C: begin
        a = {16'd0, opnd.grace};
        b = opnd.diff;
      end
      htu_pkg::ALU_HOLD_D: begin
        a = opnd.now;
        b = opnd.hold_start;
      end
      // borrow: hold still shorter than hold time
      htu_pkg::ALU_HOLD_C: begin
        a = opnd.diff;
        b = {16'd0, opnd.hold_time};
      end
      htu_pkg::ALU_IDLE_D: begin
        a = opnd.now;
        b = opnd.last_activity;
      end
      // borrow: inactivity longer than timeout
      htu_pkg::ALU_IDLE_C: begin
        a = {12'd0, opnd.idle};
        b = opnd.diff;
      end
      // restoring divide step against the shifted divisor
      htu_pkg::ALU_DIV: begin
        a = {{(32 - htu_pkg::REM_W){1'b0}}, opnd.rem};
        b = {16'd0, opnd.hold_time} << opnd.shift;
      end
      default: begin
        a = '0;
        b = '0;
      end
    endcase
  end

  assign wide          = {1'b0, a} - {1'b0, b};
  assign result.res    = wide[31:0];
  assign result.borrow = wide[32];

endmodule

// ===== rtl/hold_to_unlock_gesture_core.sv =====
// ----------------------------------------------------------------------------
// hold_to_unlock_gesture_core
// press-and-hold unlock qualifier for a touch panel lock screen
// ----------------------------------------------------------------------------
//
// channel  dir  handshake              payload
// -------  ---  ---------------------  ------------------------------------
// in_      in   in_tvalid / in_tready  tuser: action; tdata: time, touch
// out_     out  out_tvalid / out_tready tdata: outcome, percent, holding
// cfg_     in   cfg_we                 cfg_idx, cfg_wdata (no read-back)
//
// an enter item passes from its prep step straight to the result; a frame
// item takes two steps of the shared subtractor each for the grace and hold
// checks, two more for the idle check unless the hold unlocks, then, while
// a hold runs and no timeout hit, one step per quotient bit (7) for the percent
// in_tready is high only while the sequencer idles, so items are one at a time
// the result sits in an output register; the next item is taken while it waits
// a stalled output holds the sequencer in its last step until the register frees
// rst_n is synchronous, active low; it restores register defaults and clears
// the hold and all time stamps
// ----------------------------------------------------------------------------
module hold_to_unlock_gesture_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: now_ms[31:0], touch_down, just_pressed, just_released,
  //           touch_x[9:0], touch_y[9:0], zero pad
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [55:0]                       in_tdata,
  // in_tuser: action
  input  logic [0:0]                        in_tuser,
  // out_tdata: outcome[1:0], progress_percent[6:0], holding, zero pad
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [15:0]                       out_tdata,
  input  logic                              cfg_we,
  input  logic [htu_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [htu_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  // configuration registers
  logic [10:0] panel_width_r;
  logic [10:0] panel_height_r;
  logic [15:0] hold_time_r;
  logic [15:0] grace_time_r;
  logic [19:0] idle_timeout_r;
  logic        saver_only_r;

  // gesture state
  logic        hold_active_r;
  logic [31:0] hold_start_r;
  logic [31:0] last_contact_r;
  logic [31:0] last_activity_r;

  // captured item
  logic        action_r;
  logic [31:0] now_r;
  logic        down_r;
  logic        pressed_r;
  logic        released_r;
  logic [9:0]  x_r;
  logic [9:0]  y_r;

  // working registers
  htu_pkg::state_t                state_r, state_nxt;
  logic                           hit_r;
  logic [31:0]                    diff_r;
  logic [15:0]                    held_r;
  logic [htu_pkg::REM_W-1:0]      rem_r;
  logic [htu_pkg::PCT_W-2:0]      quo_r;
  logic [2:0]                     shift_r;

  // staged result
  htu_pkg::outcome_t              res_outcome_r;
  logic [htu_pkg::PCT_W-1:0]      res_pct_r;
  logic                           res_holding_r;

  // output register
  logic                           out_tvalid_r;
  logic [15:0]                    out_tdata_r;

  logic                           in_accept;
  logic                           out_load;
  htu_pkg::alu_op_t               alu_op;
  htu_pkg::alu_opnd_t             alu_opnd;
  htu_pkg::alu_res_t              alu_res;
  logic [htu_pkg::REM_W-1:0]      held_x100;

  // ---------------------------------------------------------------------------
  // button hit test on the captured position
  // ---------------------------------------------------------------------------
  localparam logic signed [13:0] SLOP = 14'(htu_pkg::HIT_SLOP);

  logic signed [13:0] w_s, h_s, bw_s, bx_s, hv_s, hh_s, by_s, x_s, y_s;
  logic               hit;

  always_comb begin
    w_s  = $signed({3'd0, panel_width_r});
    h_s  = $signed({3'd0, panel_height_r});
    x_s  = $signed({4'd0, x_r});
    y_s  = $signed({4'd0, y_r});
    // button width clamps at 200 and goes negative on very narrow panels
    bw_s = w_s - 14'sd48;
    if (bw_s > 14'sd200) begin
      bw_s = 14'sd200;
    end
    bx_s = (w_s - bw_s) >>> 1;
    // halving truncates toward zero on short panels
    hv_s = h_s - 14'sd58;
    if (hv_s < 14'sd0) begin
      hh_s = -((-hv_s) >>> 1);
    end else begin
      hh_s = hv_s >>> 1;
    end
    by_s = hh_s + 14'sd37;
    hit  = (x_s >= bx_s - SLOP) && (x_s < bx_s + bw_s + SLOP) &&
           (y_s >= by_s - SLOP) && (y_s < by_s + 14'sd58 + SLOP);
  end

  // ---------------------------------------------------------------------------
  // shared subtractor
  // ---------------------------------------------------------------------------
  always_comb begin
    alu_opnd.now           = now_r;
    alu_opnd.last_contact  = last_contact_r;
    alu_opnd.hold_start    = hold_start_r;
    alu_opnd.last_activity = last_activity_r;
    alu_opnd.diff          = diff_r;
    alu_opnd.grace         = grace_time_r;
    alu_opnd.hold_time     = hold_time_r;
    alu_opnd.idle          = idle_timeout_r;
    alu_opnd.rem           = rem_r;
    alu_opnd.shift         = shift_r;
  end

  htu_alu u_alu (
    .op     (alu_op),
    .opnd   (alu_opnd),
    .result (alu_res)
  );

  // held * 100 by shifts, held stays below the hold time here
  assign held_x100 = {1'b0, held_r, 6'd0} + {2'd0, held_r, 5'd0} + {5'd0, held_r, 2'd0};

  assign in_accept = in_tvalid && in_tready;
  assign out_load  = (state_r == htu_pkg::S_DONE) && (!out_tvalid_r || out_tready);

  // ---------------------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      htu_pkg::S_IDLE: begin
        if (in_accept) begin
          state_nxt = htu_pkg::S_PREP;
        end
      end
      htu_pkg::S_PREP: begin
        if (action_r == htu_pkg::ACT_ENTER) begin
          state_nxt = htu_pkg::S_DONE;
        end else begin
          state_nxt = htu_pkg::S_GRACE_D;
        end
      end
      htu_pkg::S_GRACE_D: state_nxt = htu_pkg::S_GRACE_C;
      htu_pkg::S_GRACE_C: state_nxt = htu_pkg::S_HOLD_D;
      htu_pkg::S_HOLD_D:  state_nxt = htu_pkg::S_HOLD_C;
      htu_pkg::S_HOLD_C: begin
        // hold complete: unlock
        if (hold_active_r && !alu_res.borrow) begin
          state_nxt = htu_pkg::S_DONE;
        end else begin
          state_nxt = htu_pkg::S_IDLE_D;
        end
      end
      htu_pkg::S_IDLE_D:  state_nxt = htu_pkg::S_IDLE_C;
      htu_pkg::S_IDLE_C: begin
        if (alu_res.borrow || !hold_active_r) begin
          state_nxt = htu_pkg::S_DONE;
        end else begin
          state_nxt = htu_pkg::S_DIV;
        end
      end
      htu_pkg::S_DIV: begin
        if (shift_r == 3'd0) begin
          state_nxt = htu_pkg::S_DONE;
        end
      end
      htu_pkg::S_DONE: begin
        if (out_load) begin
          state_nxt = htu_pkg::S_IDLE;
        end
      end
      default: state_nxt = htu_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer: outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    in_tready = 1'b0;
    alu_op    = htu_pkg::ALU_DIV;
    unique case (state_r)
      htu_pkg::S_IDLE:    in_tready = 1'b1;
      htu_pkg::S_GRACE_D: alu_op    = htu_pkg::ALU_GRACE_D;
      htu_pkg::S_GRACE_C: alu_op    = htu_pkg::ALU_GRACE_C;
      htu_pkg::S_HOLD_D:  alu_op    = htu_pkg::ALU_HOLD_D;
      htu_pkg::S_HOLD_C:  alu_op    = htu_pkg::ALU_HOLD_C;
      htu_pkg::S_IDLE_D:  alu_op    = htu_pkg::ALU_IDLE_D;
      htu_pkg::S_IDLE_C:  alu_op    = htu_pkg::ALU_IDLE_C;
      htu_pkg::S_DIV:     alu_op    = htu_pkg::ALU_DIV;
      default: begin
        in_tready = 1'b0;
        alu_op    = htu_pkg::ALU_DIV;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= htu_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // configuration writes, indexes past the list are dropped
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      panel_width_r  <= htu_pkg::RST_PANEL_WIDTH;
      panel_height_r <= htu_pkg::RST_PANEL_HEIGHT;
      hold_time_r    <= htu_pkg::RST_HOLD_TIME;
      grace_time_r   <= htu_pkg::RST_GRACE_TIME;
      idle_timeout_r <= htu_pkg::RST_IDLE_TIMEOUT;
      saver_only_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        htu_pkg::REG_PANEL_WIDTH:  panel_width_r  <= cfg_wdata[10:0];
        htu_pkg::REG_PANEL_HEIGHT: panel_height_r <= cfg_wdata[10:0];
        htu_pkg::REG_HOLD_TIME:    hold_time_r    <= cfg_wdata[15:0];
        htu_pkg::REG_GRACE_TIME:   grace_time_r   <= cfg_wdata[15:0];
        htu_pkg::REG_IDLE_TIMEOUT: idle_timeout_r <= cfg_wdata[19:0];
        htu_pkg::REG_SAVER_ONLY:   saver_only_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // item capture
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_accept) begin
      action_r   <= in_tuser[0];
      now_r      <= in_tdata[31:0];
      down_r     <= in_tdata[32];
      pressed_r  <= in_tdata[33];
      released_r <= in_tdata[34];
      x_r        <= in_tdata[44:35];
      y_r        <= in_tdata[54:45];
    end
  end

  // ---------------------------------------------------------------------------
  // gesture state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_active_r   <= 1'b0;
      hold_start_r    <= '0;
      last_contact_r  <= '0;
      last_activity_r <= '0;
    end else begin
      unique case (state_r)
        htu_pkg::S_PREP: begin
          if (action_r == htu_pkg::ACT_ENTER) begin
            hold_active_r   <= 1'b0;
            hold_start_r    <= '0;
            last_contact_r  <= '0;
            last_activity_r <= now_r;
          end else if (down_r || pressed_r || released_r) begin
            last_activity_r <= now_r;
          end
        end
        htu_pkg::S_GRACE_C: begin
          if (down_r && hit_r) begin
            if (!hold_active_r) begin
              hold_active_r <= 1'b1;
              hold_start_r  <= now_r;
            end
            last_contact_r <= now_r;
          end else if (hold_active_r && alu_res.borrow) begin
            // contact gap beyond grace drops the hold
            hold_active_r <= 1'b0;
            hold_start_r  <= '0;
          end
        end
        htu_pkg::S_HOLD_C: begin
          // unlock keeps the start stamp
          if (hold_active_r && !alu_res.borrow) begin
            hold_active_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // working registers and staged result
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= '0;
    end else begin
      unique case (state_r)
        htu_pkg::S_IDLE_C: shift_r <= htu_pkg::DIV_SHIFT;
        htu_pkg::S_DIV:    shift_r <= shift_r - 3'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      htu_pkg::S_PREP: begin
        hit_r         <= hit;
        res_outcome_r <= htu_pkg::OUT_LOCKED;
        res_pct_r     <= '0;
        res_holding_r <= 1'b0;
      end
      htu_pkg::S_GRACE_D, htu_pkg::S_HOLD_D, htu_pkg::S_IDLE_D: begin
        diff_r <= alu_res.res;
      end
      htu_pkg::S_HOLD_C: begin
        held_r <= diff_r[15:0];
        if (hold_active_r && !alu_res.borrow) begin
          res_outcome_r <= htu_pkg::OUT_UNLOCKED;
          res_pct_r     <= '0;
          res_holding_r <= 1'b0;
        end
      end
      htu_pkg::S_IDLE_C: begin
        rem_r <= held_x100;
        quo_r <= '0;
        if (alu_res.borrow) begin
          res_outcome_r <= saver_only_r ? htu_pkg::OUT_SAVER : htu_pkg::OUT_SLEEP;
          res_pct_r     <= '0;
          res_holding_r <= hold_active_r;
        end else begin
          res_outcome_r <= htu_pkg::OUT_LOCKED;
          res_pct_r     <= '0;
          res_holding_r <= hold_active_r;
        end
      end
      htu_pkg::S_DIV: begin
        // one quotient bit per step, msb first
        if (!alu_res.borrow) begin
          rem_r <= alu_res.res[htu_pkg::REM_W-1:0];
        end
        quo_r <= {quo_r[htu_pkg::PCT_W-3:0], !alu_res.borrow};
        if (shift_r == 3'd0) begin
          res_pct_r <= {quo_r, !alu_res.borrow};
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {6'd0, res_holding_r, res_pct_r, res_outcome_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== rtl/htu_checker.sv =====
// ----------------------------------------------------------------------------
// htu_checker
// port-level checks of the hold-to-unlock gesture qualifier
// ----------------------------------------------------------------------------
module htu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // one item at a time: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready right after acceptance");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[8:2] <= 7'd100)
    else $error("percent above 100");

  // unlock ends the hold and reports no progress
  a_unlock_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == htu_pkg::OUT_UNLOCKED) |-> out_tdata[9:2] == 8'd0)
    else $error("unlock with progress or hold");

  // locked and not holding means no progress
  a_idle_no_pct: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == htu_pkg::OUT_LOCKED) && !out_tdata[9]
      |-> out_tdata[8:2] == 7'd0)
    else $error("progress without hold");

endmodule

bind hold_to_unlock_gesture_core htu_checker u_htu_checker (.*);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the hold-to-unlock gesture qualifier
//
// enter and frame items go in over the input stream; a cycle-free model of the
// gesture logic runs on every accepted item and queues the result it predicts.
// each result leaving the block is compared field by field against the
// oldest queued prediction. directed cases cover the hit-test edges, the grace
// window, unlock, idle timeout and time wrap; random touch sessions then run
// under several register settings and idle patterns on both sides
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import htu_pkg::*;

  // button geometry constants of the lock screen
  localparam int BTN_MAX_W       = 200;
  localparam int BTN_SIDE_MARGIN = 48;
  localparam int BTN_H           = 58;
  localparam int BTN_Y_OFFSET    = 37;

  // frame update kind, the counterpart of ACT_ENTER
  localparam logic ACT_FRAME = ~ACT_ENTER;

  // generous bound, the slowest correct run needs far less than this
  localparam int CYCLE_LIMIT = 1_000_000;

  // one input item as it travels on the stream
  typedef struct packed {
    logic        action;
    logic [31:0] now_ms;
    logic        down;
    logic        pressed;
    logic        released;
    logic [9:0]  x;
    logic [9:0]  y;
  } touch_item_t;

  // one result item
  typedef struct packed {
    outcome_t   outcome;
    logic [6:0] percent;
    logic       holding;
  } gesture_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // in_tdata: now_ms[31:0], touch_down, just_pressed, just_released,
  //           touch_x[9:0], touch_y[9:0], zero pad
  logic [55:0] in_tdata = '0;
  // in_tuser: action
  logic [0:0]  in_tuser = '0;

  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // out_tdata: outcome[1:0], progress_percent[6:0], holding, zero pad
  logic [15:0] out_tdata;

  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  hold_to_unlock_gesture_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // gesture model: register copies and hold state
  // ---------------------------------------------------------------------------
  logic [10:0] cfg_width    = RST_PANEL_WIDTH;
  logic [10:0] cfg_height   = RST_PANEL_HEIGHT;
  logic [15:0] cfg_hold_ms  = RST_HOLD_TIME;
  logic [15:0] cfg_grace_ms = RST_GRACE_TIME;
  logic [19:0] cfg_idle_ms  = RST_IDLE_TIMEOUT;
  logic        cfg_saver    = 1'b0;

  logic        hold_on       = 1'b0;
  logic [31:0] hold_start_ms = '0;
  logic [31:0] contact_ms    = '0;
  logic [31:0] activity_ms   = '0;

  // predicted results waiting for the block to produce them
  gesture_result_t expected_q[$];

  // bookkeeping
  int error_count    = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int unlocks_seen   = 0;
  int timeouts_seen  = 0;
  int settings_used  = 1;
  int cycle_count    = 0;

  // idle behavior of both sides, in percent of cycles
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_off_left  = 0;

  // random session state
  logic [31:0] session_ms = '0;
  logic        finger_on  = 1'b0;

  // hit box of the button, slop included, as half-open ranges
  function automatic void button_box(output int xlo, output int xhi,
                                     output int ylo, output int yhi);
    int bw, bx, by;
    bw = int'(cfg_width) - BTN_SIDE_MARGIN;
    if (bw > BTN_MAX_W) bw = BTN_MAX_W;
    // signed division truncates toward zero, as the block does
    bx = (int'(cfg_width) - bw) / 2;
    by = (int'(cfg_height) - BTN_H) / 2 + BTN_Y_OFFSET;
    xlo = bx - HIT_SLOP;
    xhi = bx + bw + HIT_SLOP;
    ylo = by - HIT_SLOP;
    yhi = by + BTN_H + HIT_SLOP;
  endfunction

  function automatic logic button_hit(logic [9:0] x, logic [9:0] y);
    int xlo, xhi, ylo, yhi;
    button_box(xlo, xhi, ylo, yhi);
    return int'(x) >= xlo && int'(x) < xhi && int'(y) >= ylo && int'(y) < yhi;
  endfunction

  // advance the hold state by one item and return the result it causes
  function automatic gesture_result_t predict_gesture(touch_item_t it);
    gesture_result_t r;
    logic [31:0] contact_gap, idle_gap, held;
    r = '{outcome: OUT_LOCKED, percent: 7'd0, holding: 1'b0};
    if (it.action == ACT_ENTER) begin
      hold_on       = 1'b0;
      hold_start_ms = '0;
      contact_ms    = '0;
      activity_ms   = it.now_ms;
      return r;
    end
    if (it.down || it.pressed || it.released) activity_ms = it.now_ms;
    contact_gap = it.now_ms - contact_ms;
    if (it.down && button_hit(it.x, it.y)) begin
      if (!hold_on) begin
        hold_on       = 1'b1;
        hold_start_ms = it.now_ms;
      end
      contact_ms = it.now_ms;
    end else if (hold_on && contact_gap > {16'd0, cfg_grace_ms}) begin
      // contact lost longer than the grace window
      hold_on       = 1'b0;
      hold_start_ms = '0;
    end
    held = it.now_ms - hold_start_ms;
    if (hold_on && held >= {16'd0, cfg_hold_ms}) begin
      // start time is kept on unlock
      hold_on   = 1'b0;
      r.outcome = OUT_UNLOCKED;
      return r;
    end
    idle_gap = it.now_ms - activity_ms;
    if (idle_gap > {12'd0, cfg_idle_ms}) begin
      r.outcome = cfg_saver ? OUT_SAVER : OUT_SLEEP;
      r.holding = hold_on;
      return r;
    end
    // held is below the hold time here, so the divisor is nonzero
    if (hold_on) r.percent = 7'((held * 32'd100) / {16'd0, cfg_hold_ms});
    r.holding = hold_on;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random ready, long hold-offs on request, and the checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    gesture_result_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got.outcome = outcome_t'(out_tdata[1:0]);
      got.percent = out_tdata[8:2];
      got.holding = out_tdata[9];
      results_seen++;
      if (got.outcome == OUT_UNLOCKED) unlocks_seen++;
      if (got.outcome == OUT_SAVER || got.outcome == OUT_SLEEP) timeouts_seen++;
      if (expected_q.size() == 0) begin
        $error("result item with no prediction waiting: outcome %0d percent %0d",
               got.outcome, got.percent);
        error_count++;
      end else begin
        want = expected_q.pop_front();
        if (got.outcome !== want.outcome) begin
          $error("outcome: expected %0d, got %0d", want.outcome, got.outcome);
          error_count++;
        end
        if (got.percent !== want.percent) begin
          $error("progress_percent: expected %0d, got %0d", want.percent, got.percent);
          error_count++;
        end
        if (got.holding !== want.holding) begin
          $error("holding: expected %0d, got %0d", want.holding, got.holding);
          error_count++;
        end
      end
    end
    // a requested hold-off wins over the random ready pattern
    if (hold_off_left > 0) begin
      out_tready <= 1'b0;
      hold_off_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, expected_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // offer one item, maybe after a random gap; valid stays high afterwards
  // so that back-to-back items need no second assignment in one step
  task automatic send_item(touch_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.action;
    in_tdata  <= {1'b0, it.y, it.x, it.released, it.pressed, it.down, it.now_ms};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_q.push_back(predict_gesture(it));
    items_sent++;
  endtask

  task automatic send_enter(logic [31:0] ms);
    touch_item_t it;
    it = '0;
    it.action = ACT_ENTER;
    it.now_ms = ms;
    // payload of an enter item is ignored, so fill it with noise
    it.down = 1'($urandom);
    it.x = 10'($urandom);
    it.y = 10'($urandom);
    send_item(it);
  endtask

  task automatic send_frame(logic [31:0] ms, logic down, logic pressed, logic released,
                            logic [9:0] x, logic [9:0] y);
    send_item('{action: ACT_FRAME, now_ms: ms, down: down, pressed: pressed,
                released: released, x: x, y: y});
  endtask

  // pause the sender until every predicted result has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_PANEL_WIDTH:  cfg_width    = data[10:0];
      REG_PANEL_HEIGHT: cfg_height   = data[10:0];
      REG_HOLD_TIME:    cfg_hold_ms  = data[15:0];
      REG_GRACE_TIME:   cfg_grace_ms = data[15:0];
      REG_IDLE_TIMEOUT: cfg_idle_ms  = data[19:0];
      REG_SAVER_ONLY:   cfg_saver    = data[0];
      default: ;
    endcase
  endtask

  // reprogram every register while the block is idle
  task automatic set_config(int width, int height, int hold_ms, int grace_ms,
                            int idle_ms, int saver);
    wait_drained();
    write_reg(REG_PANEL_WIDTH,  CFG_DATA_W'(width));
    write_reg(REG_PANEL_HEIGHT, CFG_DATA_W'(height));
    write_reg(REG_HOLD_TIME,    CFG_DATA_W'(hold_ms));
    write_reg(REG_GRACE_TIME,   CFG_DATA_W'(grace_ms));
    write_reg(REG_IDLE_TIMEOUT, CFG_DATA_W'(idle_ms));
    write_reg(REG_SAVER_ONLY,   CFG_DATA_W'(saver));
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  task automatic randomize_settings();
    set_config($urandom_range(64, 1024), $urandom_range(64, 1024),
               $urandom_range(1, 1500), $urandom_range(0, 400),
               $urandom_range(1, 20000), $urandom_range(0, 1));
  endtask

  function automatic logic [9:0] clamp_coord(int v);
    if (v < 0) return 10'd0;
    if (v > 1023) return 10'd1023;
    return 10'(v);
  endfunction

  // random touch sessions: mostly a finger pressing, holding and lifting on
  // or near the button at frame pace, with noise flags, wild jumps and
  // occasional re-entries mixed in
  task automatic run_gestures(int count);
    int i, pick, xlo, xhi, ylo, yhi;
    logic [31:0] step_ms;
    logic was_on, down, pressed, released;
    logic [9:0] px, py;
    session_ms = $urandom();
    finger_on  = 1'b0;
    send_enter(session_ms);
    for (i = 1; i < count; i++) begin
      if ($urandom_range(99) < 3) begin
        send_enter(session_ms);
      end else begin
        pick = $urandom_range(99);
        if (pick < 78)      step_ms = $urandom_range(1, 40);
        else if (pick < 86) step_ms = $urandom_range(0, 2 * int'(cfg_grace_ms) + 2);
        else if (pick < 93) step_ms = $urandom_range(0, 2 * int'(cfg_idle_ms) + 2);
        else if (pick < 98) step_ms = $urandom_range(0, int'(cfg_hold_ms) + 50);
        else                step_ms = $urandom();
        session_ms = session_ms + step_ms;

        was_on = finger_on;
        if ($urandom_range(99) < (finger_on ? 10 : 25)) finger_on = !finger_on;
        down     = finger_on;
        pressed  = finger_on && !was_on;
        released = !finger_on && was_on;
        // inconsistent touch flags now and then
        if ($urandom_range(99) < 6) {down, pressed, released} = 3'($urandom);

        button_box(xlo, xhi, ylo, yhi);
        pick = $urandom_range(99);
        if (pick < 70 && xlo < xhi && ylo < yhi) begin
          px = $urandom_range(clamp_coord(xlo), clamp_coord(xhi - 1));
          py = $urandom_range(clamp_coord(ylo), clamp_coord(yhi - 1));
        end else if (pick < 85) begin
          // just inside or just outside one of the edges
          px = clamp_coord(($urandom_range(1) ? xlo : xhi) + $urandom_range(2) - 1);
          py = clamp_coord(($urandom_range(1) ? ylo : yhi) + $urandom_range(2) - 1);
          if ($urandom_range(1)) px = clamp_coord((xlo + xhi) / 2);
          else                   py = clamp_coord((ylo + yhi) / 2);
        end else begin
          px = 10'($urandom);
          py = 10'($urandom);
        end
        send_frame(session_ms, down, pressed, released, px, py);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // directed tests, all on the reset register values
  // ---------------------------------------------------------------------------

  // press on the button, hold to half way, then to completion; far corners miss
  task automatic test_hold_and_unlock();
    int xlo, xhi, ylo, yhi;
    logic [9:0] cx, cy;
    button_box(xlo, xhi, ylo, yhi);
    cx = clamp_coord((xlo + xhi) / 2);
    cy = clamp_coord((ylo + yhi) / 2);
    send_enter(32'd1000);
    send_frame(32'd1020, 1'b1, 1'b1, 1'b0, cx, cy);
    send_frame(32'd1520, 1'b1, 1'b0, 1'b0, cx, cy);
    send_frame(32'd2020, 1'b1, 1'b0, 1'b0, cx, cy);
    send_frame(32'd2040, 1'b1, 1'b1, 1'b0, 10'd0, 10'd0);
    send_frame(32'd2060, 1'b1, 1'b0, 1'b1, 10'd1023, 10'd1023);
  endtask

  // a lift of exactly the grace time is forgiven, one more millisecond is not
  task automatic test_grace_gap();
    int xlo, xhi, ylo, yhi;
    logic [9:0] cx, cy;
    logic [31:0] t0;
    button_box(xlo, xhi, ylo, yhi);
    cx = clamp_coord((xlo + xhi) / 2);
    cy = clamp_coord((ylo + yhi) / 2);
    t0 = 32'd50000;
    send_enter(t0);
    send_frame(t0 + 10, 1'b1, 1'b1, 1'b0, cx, cy);
    send_frame(t0 + 10 + RST_GRACE_TIME, 1'b0, 1'b0, 1'b1, cx, cy);
    send_frame(t0 + 170, 1'b1, 1'b1, 1'b0, cx, cy);
    send_frame(t0 + 171 + RST_GRACE_TIME, 1'b0, 1'b0, 1'b1, cx, cy);
  endtask

  // first and last pixel of the slop band on each side, and one beyond
  task automatic test_hit_edges();
    int xlo, xhi, ylo, yhi;
    logic [9:0] cx, cy;
    logic [31:0] t;
    button_box(xlo, xhi, ylo, yhi);
    cx = clamp_coord((xlo + xhi) / 2);
    cy = clamp_coord((ylo + yhi) / 2);
    t = 32'd90000;
    send_enter(t);
    send_frame(t + 20,  1'b1, 1'b1, 1'b0, clamp_coord(xlo), cy);
    send_frame(t + 40,  1'b1, 1'b0, 1'b0, clamp_coord(xlo - 1), cy);
    send_frame(t + 240, 1'b1, 1'b0, 1'b0, clamp_coord(xhi - 1), cy);
    send_frame(t + 260, 1'b1, 1'b0, 1'b0, clamp_coord(xhi), cy);
    send_frame(t + 460, 1'b1, 1'b0, 1'b0, cx, clamp_coord(ylo));
    send_frame(t + 480, 1'b1, 1'b0, 1'b0, cx, clamp_coord(ylo - 1));
    send_frame(t + 680, 1'b1, 1'b0, 1'b0, cx, clamp_coord(yhi - 1));
    send_frame(t + 700, 1'b1, 1'b0, 1'b0, cx, clamp_coord(yhi));
  endtask

  // no touch for one millisecond past the idle timeout
  task automatic test_idle_timeout();
    send_enter(32'd200000);
    send_frame(32'd200001 + RST_IDLE_TIMEOUT, 1'b0, 1'b0, 1'b0, 10'd512, 10'd512);
  endtask

  // a hold that starts just before the time stamp wraps and ends after it
  task automatic test_time_wrap();
    int xlo, xhi, ylo, yhi;
    logic [9:0] cx, cy;
    button_box(xlo, xhi, ylo, yhi);
    cx = clamp_coord((xlo + xhi) / 2);
    cy = clamp_coord((ylo + yhi) / 2);
    send_enter(32'hFFFF_FF00);
    send_frame(32'hFFFF_FFF0, 1'b1, 1'b1, 1'b0, cx, cy);
    send_frame(32'h0000_0400, 1'b1, 1'b0, 1'b0, cx, cy);
  endtask

  // ---------------------------------------------------------------------------
  // register setting phases
  // ---------------------------------------------------------------------------

  task automatic test_reset_settings_random();
    run_gestures(300);
  endtask

  task automatic test_min_settings();
    set_config(64, 64, 1, 0, 1, 1);
    run_gestures(100);
  endtask

  task automatic test_max_settings();
    set_config(1024, 1024, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 0);
    run_gestures(100);
  endtask

  // narrow panel leaves an empty button; zero hold time unlocks on contact
  task automatic test_zero_hold_and_narrow_panel();
    set_config(30, 41, 0, 150, 10000, 1);
    run_gestures(50);
    set_config(320, 240, 0, 150, 10000, 0);
    run_gestures(50);
  endtask

  task automatic test_random_settings(int phases, int per_phase);
    int p;
    for (p = 0; p < phases; p++) begin
      randomize_settings();
      run_gestures(per_phase);
    end
  endtask

  // receiver holds off for a long stretch while items keep coming, so the
  // block fills up and drops in_tready; then the sender waits for a drain
  task automatic test_backpressure();
    randomize_settings();
    hold_off_left = 300;
    run_gestures(40);
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // sequence of tests
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender idles a quarter of the time, receiver about half
    send_idle_pct = 26;
    recv_idle_pct = 55;
    test_hold_and_unlock();
    test_grace_gap();
    test_hit_edges();
    test_idle_timeout();
    test_time_wrap();
    test_reset_settings_random();
    test_min_settings();
    test_max_settings();
    test_zero_hold_and_narrow_panel();

    // roles swapped
    send_idle_pct = 55;
    recv_idle_pct = 26;
    test_random_settings(3, 110);

    // full speed on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random_settings(2, 150);

    wait_drained();
    $display("sent %0d items under %0d register settings, checked %0d results",
             items_sent, settings_used, results_seen);
    $display("results included %0d unlocks and %0d idle timeouts",
             unlocks_seen, timeouts_seen);
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (expected_q.size() != 0)
        $error("%0d predicted results never came out", expected_q.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== hold_to_unlock_gesture_core.f =====
rtl/htu_pkg.sv
rtl/htu_alu.sv
rtl/hold_to_unlock_gesture_core.sv
rtl/htu_checker.sv
tb/tb_top.sv
